@@ rtl/datetime_text_to_epoch_parser_core_macros.svh @@
// Assertion macros for the date-time parser checker.
// Included by the checker file; no other dependencies.
`ifndef DATETIME_TEXT_TO_EPOCH_PARSER_CORE_MACROS_SVH
`define DATETIME_TEXT_TO_EPOCH_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DTEP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DTEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dtep_pkg.sv @@
// Shared types and widths for the date-time text to epoch parser.
// Used by the controller, the datapath, the top level and the checker.
package dtep_pkg;

  localparam int EPOCH_W = 39;
  localparam int FRAC_W  = 20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_char;
    logic capture;
    logic era;
    logic yoe;
    logic doe;
    logic days;
    logic secs;
    logic scale;
    logic finish;
  } dtep_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frac_full;
  } dtep_status_t;

endpackage

@@ rtl/dtep_ctrl.sv @@
// Controller for the date-time parser: item flow and epoch sequencing.
// Depends on dtep_pkg for the command and status structs.
module dtep_ctrl import dtep_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         end_token,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output dtep_cmd_t    cmd,
  input  dtep_status_t status
);

  typedef enum logic [6:0] {
    S_RUN   = 7'b0000001,
    S_ERA   = 7'b0000010,
    S_YOE   = 7'b0000100,
    S_DOE   = 7'b0001000,
    S_DAYS  = 7'b0010000,
    S_SECS  = 7'b0100000,
    S_SCALE = 7'b1000000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_full;
  logic        out_full_next;
  logic        accept;

  // Characters flow while a result waits; only a new end item has to wait.
  assign in_stall  = (state != S_RUN) || (out_full && end_token);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_full;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (accept) begin
          if (end_token) begin
            cmd.capture = 1'b1;
            state_next  = S_ERA;
          end else begin
            cmd.take_char = 1'b1;
          end
        end
      end
      S_ERA: begin
        cmd.era    = 1'b1;
        state_next = S_YOE;
      end
      S_YOE: begin
        cmd.yoe    = 1'b1;
        state_next = S_DOE;
      end
      S_DOE: begin
        cmd.doe    = 1'b1;
        state_next = S_DAYS;
      end
      S_DAYS: begin
        cmd.days   = 1'b1;
        state_next = S_SECS;
      end
      S_SECS: begin
        cmd.secs   = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (status.frac_full) begin
          cmd.finish = 1'b1;
          state_next = S_RUN;
        end else begin
          cmd.scale = 1'b1;
        end
      end
      default: state_next = S_RUN;
    endcase
    out_full_next = cmd.finish || (out_full && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

@@ rtl/dtep_datapath.sv @@
// Datapath for the date-time parser: character lexer, field registers,
// days-from-civil stages, fraction scaling and the result register.
// Depends on dtep_pkg for the command and status structs and field widths.
module dtep_datapath import dtep_pkg::*; #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dtep_cmd_t                 cmd,
  output dtep_status_t              status,
  input  logic [7:0]                symbol,
  output logic                      ok,
  output logic signed [EPOCH_W-1:0] epoch_seconds,
  output logic [FRAC_W-1:0]         fraction_micro
);

  localparam int              FCW       = $clog2(FRAC_DIGITS + 1);
  localparam logic [FCW-1:0]  FRAC_LAST = FCW'(FRAC_DIGITS);

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_Z     = 8'h5A;

  // floor(ys / 400) as (ys * ERA_RECIP) >> ERA_SHIFT, then one correction
  localparam logic [13:0]        ERA_RECIP   = 14'd10486;
  localparam int                 ERA_SHIFT   = 22;
  localparam logic [13:0]        YEARS_ERA   = 14'd400;
  localparam logic signed [24:0] DAYS_ERA    = 25'sd146097;
  localparam logic signed [24:0] EPOCH_DAYS  = 25'sd719468;
  localparam logic signed [39:0] SEC_PER_DAY = 40'sd86400;

  typedef enum logic [10:0] {
    PH_LEAD   = 11'h001,
    PH_YEAR   = 11'h002,
    PH_MONTH  = 11'h004,
    PH_DAY    = 11'h008,
    PH_SPACE  = 11'h010,
    PH_HOUR   = 11'h020,
    PH_MINUTE = 11'h040,
    PH_SECOND = 11'h080,
    PH_FRAC   = 11'h100,
    PH_ZED    = 11'h200,
    PH_TRAIL  = 11'h400
  } phase_t;

  // Day of the March-based year on which a month starts.
  function automatic logic [8:0] month_start(input logic [6:0] m);
    logic [8:0] r;
    unique case (m)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] add_digit(input logic [6:0] v, input logic [3:0] d);
    return 7'(v * 7'd10 + 7'(d));
  endfunction

  // Lexer state
  phase_t           phase, phase_next;
  logic [2:0]       dcount, dcount_next;
  logic [13:0]      year, year_next;
  logic [6:0]       month, month_next;
  logic [6:0]       day, day_next;
  logic [6:0]       hour, hour_next;
  logic [6:0]       minute, minute_next;
  logic [6:0]       second, second_next;
  logic [FRAC_W-1:0] frac, frac_next;
  logic [FCW-1:0]   fcount, fcount_next;
  logic             err, err_next;

  logic       dg, ws, have, small_ovf, bad, accepting, ok_now;
  logic [3:0] dv;
  logic [2:0] small_inc;
  logic [FCW-1:0] fcount_inc;

  // Epoch stages
  logic                     ok_r;
  logic [13:0]              ys, ys_r;
  logic [8:0]               doy, doy_r;
  logic [16:0]              tod, tod_r;
  logic [27:0]              est_prod;
  logic [4:0]               est_r;
  logic [13:0]              est_x400;
  logic [4:0]               era_r;
  logic [8:0]               yoe_r;
  logic [1:0]               cent;
  logic [17:0]              doe, doe_r;
  logic signed [5:0]        era_m1;
  logic signed [24:0]       days_wide;
  logic signed [22:0]       days_r;
  logic signed [39:0]       secs_wide;
  logic signed [EPOCH_W-1:0] secs_r;

  assign dg         = (symbol >= CHAR_0) && (symbol <= CHAR_9);
  assign ws         = (symbol == CHAR_SPACE) || ((symbol >= CHAR_TAB) && (symbol <= CHAR_CR));
  assign dv         = symbol[3:0];
  assign have       = (dcount != 3'd0);
  assign small_ovf  = (dcount >= 3'd2);
  assign small_inc  = dcount + 3'd1;
  assign fcount_inc = fcount + FCW'(1);

  assign status.frac_full = (fcount == FRAC_LAST);

  always_comb begin
    phase_next  = phase;
    dcount_next = dcount;
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    frac_next   = frac;
    fcount_next = fcount;
    bad         = 1'b0;
    unique case (phase)
      PH_LEAD: begin
        if (dg) begin
          year_next   = 14'(dv);
          dcount_next = 3'd1;
          phase_next  = PH_YEAR;
        end else if (!ws) begin
          bad = 1'b1;
        end
      end
      PH_YEAR: begin
        if (dg && dcount < 3'd4) begin
          year_next   = 14'(year * 14'd10 + 14'(dv));
          dcount_next = small_inc;
        end else if (symbol == CHAR_DASH && dcount == 3'd4) begin
          dcount_next = 3'd0;
          phase_next  = PH_MONTH;
        end else begin
          bad = 1'b1;
        end
      end
      PH_MONTH: begin
        if (dg) begin
          if (small_ovf) begin
            bad = 1'b1;
          end else begin
            month_next  = add_digit(month, dv);
            dcount_next = small_inc;
          end
        end else if (symbol == CHAR_DASH && have) begin
          dcount_next = 3'd0;
          phase_next  = PH_DAY;
        end else begin
          bad = 1'b1;
        end
      end
      PH_DAY: begin
        if (dg) begin
          if (small_ovf) begin
            bad = 1'b1;
          end else begin
            day_next    = add_digit(day, dv);
            dcount_next = small_inc;
          end
        end else if (have && symbol == CHAR_SPACE) begin
          phase_next = PH_SPACE;
        end else if (have && symbol == CHAR_T) begin
          dcount_next = 3'd0;
          phase_next  = PH_HOUR;
        end else if (have && ws) begin
          phase_next = PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SPACE: begin
        // a digit makes the space a separator, anything blank ends the token
        if (dg) begin
          hour_next   = 7'(dv);
          dcount_next = 3'd1;
          phase_next  = PH_HOUR;
        end else if (ws) begin
          phase_next = PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      PH_HOUR: begin
        if (dg) begin
          if (small_ovf) begin
            bad = 1'b1;
          end else begin
            hour_next   = add_digit(hour, dv);
            dcount_next = small_inc;
          end
        end else if (symbol == CHAR_COLON && have) begin
          dcount_next = 3'd0;
          phase_next  = PH_MINUTE;
        end else begin
          bad = 1'b1;
        end
      end
      PH_MINUTE: begin
        if (dg) begin
          if (small_ovf) begin
            bad = 1'b1;
          end else begin
            minute_next = add_digit(minute, dv);
            dcount_next = small_inc;
          end
        end else if (have && symbol == CHAR_COLON) begin
          dcount_next = 3'd0;
          phase_next  = PH_SECOND;
        end else if (have && symbol == CHAR_Z) begin
          phase_next = PH_ZED;
        end else if (have && ws) begin
          phase_next = PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SECOND: begin
        if (dg) begin
          if (small_ovf) begin
            bad = 1'b1;
          end else begin
            second_next = add_digit(second, dv);
            dcount_next = small_inc;
          end
        end else if (have && symbol == CHAR_DOT) begin
          phase_next = PH_FRAC;
        end else if (have && symbol == CHAR_Z) begin
          phase_next = PH_ZED;
        end else if (have && ws) begin
          phase_next = PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      PH_FRAC: begin
        if (dg) begin
          // drop digits past the kept precision
          if (fcount < FRAC_LAST) begin
            frac_next   = FRAC_W'(frac * FRAC_W'(10) + FRAC_W'(dv));
            fcount_next = fcount_inc;
          end
        end else if (fcount != '0 && symbol == CHAR_Z) begin
          phase_next = PH_ZED;
        end else if (fcount != '0 && ws) begin
          phase_next = PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ZED, PH_TRAIL: begin
        if (ws) begin
          phase_next = PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
    err_next = err || bad;
  end

  always_comb begin
    unique case (phase)
      PH_DAY, PH_MINUTE, PH_SECOND: accepting = have;
      PH_FRAC:                      accepting = (fcount != '0);
      PH_SPACE, PH_ZED, PH_TRAIL:   accepting = 1'b1;
      default:                      accepting = 1'b0;
    endcase
  end

  assign ok_now = !err && accepting
               && (month >= 7'd1) && (month <= 7'd12)
               && (day >= 7'd1) && (day <= 7'd31)
               && (hour <= 7'd23) && (minute <= 7'd59) && (second <= 7'd60);

  // January and February count to the previous March-based year.
  assign ys  = 14'(year + YEARS_ERA - 14'(month <= 7'd2));
  assign doy = 9'(month_start(month) + 9'(day) - 9'd1);
  assign tod = 17'(17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second));

  assign est_prod = 28'(ys_r) * 28'(ERA_RECIP);
  assign est_x400 = 14'(est_r * YEARS_ERA);

  always_comb begin
    if (yoe_r >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe_r >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe_r >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
  end

  assign doe = 18'(18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(cent) + 18'(doy_r));

  assign era_m1    = $signed({1'b0, era_r}) - 6'sd1;
  assign days_wide = 25'(era_m1) * DAYS_ERA + $signed({7'b0, doe_r}) - EPOCH_DAYS;
  assign secs_wide = 40'(days_r) * SEC_PER_DAY + $signed({23'b0, tod_r});

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      phase  <= PH_LEAD;
      dcount <= 3'd0;
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      frac   <= '0;
      fcount <= '0;
      err    <= 1'b0;
    end else if (cmd.take_char && !err) begin
      phase  <= phase_next;
      dcount <= dcount_next;
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      frac   <= frac_next;
      fcount <= fcount_next;
      err    <= err_next;
    end else if (cmd.scale) begin
      // pad the fraction out to the full precision
      frac   <= FRAC_W'(frac * FRAC_W'(10));
      fcount <= fcount_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok_r  <= ok_now;
      ys_r  <= ys;
      doy_r <= doy;
      tod_r <= tod;
    end
    if (cmd.era) begin
      est_r <= est_prod[ERA_SHIFT +: 5];
    end
    if (cmd.yoe) begin
      if (est_x400 > ys_r) begin
        era_r <= est_r - 5'd1;
        yoe_r <= 9'(ys_r - est_x400 + YEARS_ERA);
      end else begin
        era_r <= est_r;
        yoe_r <= 9'(ys_r - est_x400);
      end
    end
    if (cmd.doe) begin
      doe_r <= doe;
    end
    if (cmd.days) begin
      days_r <= 23'(days_wide);
    end
    if (cmd.secs) begin
      secs_r <= EPOCH_W'(secs_wide);
    end
    if (cmd.finish) begin
      ok             <= ok_r;
      epoch_seconds  <= ok_r ? secs_r : '0;
      fraction_micro <= ok_r ? frac : '0;
    end
  end

endmodule

@@ rtl/datetime_text_to_epoch_parser_core.sv @@
// Date-time text to Unix epoch parser, top level.
// Usage:
//   The input channel (in_valid / in_stall) carries one item per character:
//   symbol holds the ASCII code, end_token marks the item that closes the
//   token and carries no character. Characters are taken one per cycle
//   unless a token is in the computation. The end item starts the epoch
//   computation; the output channel (out_valid / out_stall) then presents
//   ok, epoch_seconds and fraction_micro. ok is 0 for a malformed or
//   out-of-range token, and the other fields are zero in that case.
//   After the end item the days-from-civil chain runs as five registered
//   steps, and the fraction is then padded to FRAC_DIGITS digits by one
//   multiply-by-ten per cycle. One token is in the computation at a time.
//   The result sits in an output register; characters of the next token are
//   taken while it waits, and only the next end item is held off until the
//   receiver takes it. A stalled result holds its value.
//   Reset (rst, synchronous) returns the lexer to leading whitespace and
//   drops any pending result.
// Depends on dtep_pkg, dtep_ctrl and dtep_datapath.
module datetime_text_to_epoch_parser_core import dtep_pkg::*; #(
  parameter int FRAC_DIGITS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                symbol,
  input  logic                      end_token,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic signed [EPOCH_W-1:0] epoch_seconds,
  output logic [FRAC_W-1:0]         fraction_micro
);

  dtep_cmd_t    cmd;
  dtep_status_t status;

  dtep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .end_token (end_token),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  dtep_datapath #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .symbol         (symbol),
    .ok             (ok),
    .epoch_seconds  (epoch_seconds),
    .fraction_micro (fraction_micro)
  );

endmodule

@@ rtl/dtep_checker.sv @@
// Port-level checker for the date-time parser, bound to the top level.
// Depends on dtep_pkg and the assertion macro header.
`include "datetime_text_to_epoch_parser_core_macros.svh"

module dtep_checker import dtep_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      end_token,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      ok,
  input logic signed [EPOCH_W-1:0] epoch_seconds,
  input logic [FRAC_W-1:0]         fraction_micro
);

  `DTEP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(ok) && $stable(epoch_seconds) && $stable(fraction_micro), "stalled result changed")
  `DTEP_ASSERT_IMPL(a_reject_zero, clk, rst, out_valid && !ok, epoch_seconds == '0 && fraction_micro == '0, "rejected result carries nonzero fields")
  `DTEP_ASSERT_NEXT(a_busy_after_end, clk, rst, in_valid && !in_stall && end_token, in_stall && !out_valid, "end item not followed by computation")
  `DTEP_ASSERT_IMPL(a_end_waits, clk, rst, out_valid && in_valid && end_token, in_stall, "end item taken while result pending")

endmodule

bind datetime_text_to_epoch_parser_core dtep_checker u_dtep_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .end_token      (end_token),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .ok             (ok),
  .epoch_seconds  (epoch_seconds),
  .fraction_micro (fraction_micro)
);
